/* hw/rtl/reinhard_global_tone_map_defines.svh */
// assertion helpers for the tone map rtl
`ifndef REINHARD_GLOBAL_TONE_MAP_DEFINES_SVH
`define REINHARD_GLOBAL_TONE_MAP_DEFINES_SVH

// same-cycle implication
`define RGTM_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rgtm assertion failed");

// next-cycle implication
`define RGTM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rgtm assertion failed");

`endif

/* hw/rtl/rgtm_pkg.sv */
package rgtm_pkg;

	localparam int FRAC = 16;
	localparam logic [26:0] LOG_BIAS = 27'd66;
	localparam logic [23:0] AVG_MAX = 24'hFFFFFF;
	localparam logic [29:0] SCALE_MAX = 30'h3FFFFFFF;

	typedef enum logic [1:0] {
		OP_ACCUM  = 2'd0,
		OP_FINISH = 2'd1,
		OP_MAP    = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		RK_PIXEL        = 2'd0,
		RK_AVERAGE      = 2'd1,
		RK_NO_PIXELS    = 2'd2,
		RK_NOT_FINISHED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_KEY   = 2'd0,
		REG_WRED  = 2'd1,
		REG_WGRN  = 2'd2,
		REG_WBLU  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [39:0] wprod;
		logic [15:0] mapped;
		logic        done;
	} lane_res_t;

	// Q2.30 value of 2^(2^-idx), each from a truncating integer square root of the one before
	function automatic logic [31:0] exp2_root(input int idx);
		logic [63:0] r;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] res;
		r = 64'd1 << 31;
		for (int i = 1; i <= idx; i++) begin
			y = r << 30;
			res = '0;
			for (int k = 31; k >= 0; k--) begin
				t = res | (64'd1 << k);
				if (t * t <= y)
					res = t;
			end
			r = res;
		end
		return r[31:0];
	endfunction

endpackage

/* hw/rtl/reinhard_global_tone_map.sv */
// channel   | handshake                | payload
// item in   | start, busy              | opcode, red_in, green_in, blue_in
// result    | result_valid (strobe)    | result_kind, red_out, green_out, blue_out,
//           |                          | average_luminance
// config    | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// accumulate runs the lane products, the luminance sum and 16 squarings in the log2 unit
// map runs the 16-step divider in each channel lane
// finish runs two passes of the 46-step divider, with the exp2 unit between them
// errors come back the cycle after the item; opcode 3 and a full pixel count give nothing
// all control clears on reset; results cannot be stalled and show for one cycle
`include "reinhard_global_tone_map_defines.svh"

module reinhard_global_tone_map #(
	parameter int MAX_PIXELS_LOG2 = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [23:0] red_in,
	input  logic [23:0] green_in,
	input  logic [23:0] blue_in,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic [23:0] average_luminance
);
	import rgtm_pkg::*;

	localparam int CW = MAX_PIXELS_LOG2 + 1;
	localparam int DW = (CW > 24) ? CW : 24;
	localparam int NW = 46;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LANE  = 8'b0000_0010,
		ST_SUM   = 8'b0000_0100,
		ST_LOG   = 8'b0000_1000,
		ST_MAP   = 8'b0001_0000,
		ST_MEAN  = 8'b0010_0000,
		ST_EXP   = 8'b0100_0000,
		ST_SCALE = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [19:0]        key_q;
	logic [15:0]        wred_q;
	logic [15:0]        wgrn_q;
	logic [15:0]        wblu_q;
	logic signed [45:0] log_sum_q;
	logic [CW-1:0]      count_q;
	logic [29:0]        scale_q;
	logic               ready_q;
	logic [26:0]        x_q;
	logic               neg_q;
	logic [23:0]        avg_q;
	logic               res_valid_q;
	kind_t              kind_q;
	logic [15:0]        rout_q;
	logic [15:0]        gout_q;
	logic [15:0]        bout_q;
	logic [23:0]        aout_q;

	lane_res_t          lane_r;
	lane_res_t          lane_g;
	lane_res_t          lane_b;
	logic               accept;
	logic               lane_load;
	logic [41:0]        lum_sum;
	logic               div_start;
	logic [NW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	logic [NW-1:0]      div_quo;
	logic               div_done;
	logic [NW-1:0]      sum_mag;
	logic signed [45:0] mean;
	logic signed [23:0] log_val;
	logic               log_done;
	logic [23:0]        exp_avg;
	logic               exp_done;
	logic signed [46:0] sum_next;
	logic signed [45:0] sum_sat;

	assign busy = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;
	assign lane_load = accept && ((opcode_t'(opcode) == OP_ACCUM && !count_q[CW-1]) ||
		(opcode_t'(opcode) == OP_MAP && ready_q));

	rgtm_lane u_lane_r (.clk, .arst_n, .load(lane_load), .chan(red_in), .weight(wred_q),
		.scale(scale_q), .res(lane_r));
	rgtm_lane u_lane_g (.clk, .arst_n, .load(lane_load), .chan(green_in), .weight(wgrn_q),
		.scale(scale_q), .res(lane_g));
	rgtm_lane u_lane_b (.clk, .arst_n, .load(lane_load), .chan(blue_in), .weight(wblu_q),
		.scale(scale_q), .res(lane_b));

	always_comb begin
		lum_sum = 42'(lane_r.wprod) + 42'(lane_g.wprod) + 42'(lane_b.wprod);
		sum_mag = log_sum_q[45] ? NW'(-log_sum_q) : NW'(log_sum_q);
		mean = neg_q ? -$signed(div_quo) : $signed(div_quo);
		sum_next = 47'(log_sum_q) + 47'(log_val);
		if (sum_next[46] != sum_next[45])
			sum_sat = sum_next[46] ? {1'b1, 45'd0} : {1'b0, {45{1'b1}}};
		else
			sum_sat = sum_next[45:0];
	end

	// one divider serves the mean and then the scale
	always_comb begin
		div_start = 1'b0;
		div_num = NW'({key_q, 16'd0});
		div_den = (exp_avg == '0) ? DW'(1) : DW'(exp_avg);
		if (state_q == ST_IDLE) begin
			div_num = sum_mag;
			div_den = DW'(count_q);
			div_start = accept && opcode_t'(opcode) == OP_FINISH && count_q != '0;
		end else if (state_q == ST_EXP) begin
			div_start = exp_done;
		end
	end

	rgtm_div #(.NW(NW), .DW(DW)) u_div (.clk, .arst_n, .start(div_start), .num(div_num),
		.den(div_den), .quo(div_quo), .done(div_done));

	rgtm_log2 u_log2 (.clk, .arst_n, .start(state_q == ST_SUM), .x(x_q), .val(log_val),
		.done(log_done));

	rgtm_exp2 u_exp2 (.clk, .arst_n, .start(state_q == ST_MEAN && div_done), .mean(mean),
		.avg(exp_avg), .done(exp_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q <= 20'd11796;
			wred_q <= 16'd13933;
			wgrn_q <= 16'd46871;
			wblu_q <= 16'd4732;
			log_sum_q <= '0;
			count_q <= '0;
			scale_q <= '0;
			ready_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_KEY:  key_q <= cfg_data;
					REG_WRED: wred_q <= cfg_data[15:0];
					REG_WGRN: wgrn_q <= cfg_data[15:0];
					REG_WBLU: wblu_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode_t'(opcode))
							OP_ACCUM: begin
								if (!count_q[CW-1])
									state_q <= ST_LANE;
							end
							OP_FINISH: begin
								if (count_q == '0)
									res_valid_q <= 1'b1;
								else
									state_q <= ST_MEAN;
							end
							OP_MAP: begin
								if (!ready_q)
									res_valid_q <= 1'b1;
								else
									state_q <= ST_MAP;
							end
							default: ;
						endcase
					end
				end
				ST_LANE:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_LOG;
				ST_LOG: begin
					if (log_done) begin
						log_sum_q <= sum_sat;
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MAP: begin
					if (lane_r.done) begin
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MEAN: begin
					if (div_done)
						state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (exp_done)
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (div_done) begin
						scale_q <= (div_quo[NW-1:30] != '0) ? SCALE_MAX : div_quo[29:0];
						ready_q <= 1'b1;
						log_sum_q <= '0;
						count_q <= '0;
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload and datapath holding registers
	always_ff @(posedge clk) begin
		if (state_q == ST_LANE)
			x_q <= 27'(lum_sum >> 16) + LOG_BIAS;
		if (accept)
			neg_q <= log_sum_q[45];
		if (state_q == ST_EXP && exp_done)
			avg_q <= exp_avg;
		case (state_q)
			ST_IDLE: begin
				kind_q <= (opcode_t'(opcode) == OP_FINISH) ? RK_NO_PIXELS : RK_NOT_FINISHED;
				rout_q <= '0;
				gout_q <= '0;
				bout_q <= '0;
				aout_q <= '0;
			end
			ST_MAP: begin
				kind_q <= RK_PIXEL;
				rout_q <= lane_r.mapped;
				gout_q <= lane_g.mapped;
				bout_q <= lane_b.mapped;
				aout_q <= '0;
			end
			ST_SCALE: begin
				kind_q <= RK_AVERAGE;
				rout_q <= '0;
				gout_q <= '0;
				bout_q <= '0;
				aout_q <= avg_q;
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result_kind = kind_q;
	assign red_out = rout_q;
	assign green_out = gout_q;
	assign blue_out = bout_q;
	assign average_luminance = aout_q;

	`RGTM_ASSERT_NOW(a_count_cap, count_q[CW-1], count_q[CW-2:0] == '0)
	`RGTM_ASSERT_NOW(a_pixel_fields, result_valid && result_kind == RK_PIXEL, average_luminance == '0 && ready_q)
	`RGTM_ASSERT_NEXT(a_map_needs_scale, state_q == ST_MAP, ready_q)
endmodule

/* hw/rtl/rgtm_div.sv */
module rgtm_div #(
	parameter int NW = 46,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          done
);
	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   num_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DW:0]     shifted;
	logic [DW:0]     diff;
	logic            ge;

	always_comb begin
		shifted = {rem_q, num_q[NW-1]};
		ge = shifted >= {1'b0, den_q};
		diff = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(NW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign quo = num_q;
	assign done = done_q;
endmodule

/* hw/rtl/rgtm_lane.sv */
module rgtm_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [23:0]          chan,
	input  logic [15:0]          weight,
	input  logic [29:0]          scale,
	output rgtm_pkg::lane_res_t  res
);
	import rgtm_pkg::*;

	logic [39:0] wprod_s1;
	logic [37:0] v_s1;
	logic        prime_q;
	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [38:0] rem_q;
	logic [38:0] den_q;
	logic [15:0] quo_q;
	logic [39:0] rem2;
	logic [39:0] trial;
	logic        ge;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge = rem2 >= {1'b0, den_q};
		trial = rem2 - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= 1'b0;
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			prime_q <= load;
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b0;
			end else if (prime_q) begin
				cnt_q <= 5'd16;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// v/(1+v): remainder starts at v, sixteen fraction bits follow
	always_ff @(posedge clk) begin
		if (load) begin
			wprod_s1 <= 40'(weight) * 40'(chan);
			v_s1 <= 38'((54'(chan) * 54'(scale)) >> FRAC);
		end
		if (prime_q) begin
			rem_q <= 39'(v_s1);
			den_q <= 39'(v_s1) + (39'd1 << FRAC);
		end else if (run_q) begin
			rem_q <= ge ? trial[38:0] : rem2[38:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign res.wprod = wprod_s1;
	assign res.mapped = quo_q;
	assign res.done = done_q;
endmodule

/* hw/rtl/rgtm_log2.sv */
module rgtm_log2 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [26:0]        x,
	output logic signed [23:0] val,
	output logic               done
);
	logic [4:0]  p;
	logic [30:0] m0;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [4:0]  pexp_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [61:0] sq;
	logic [31:0] t;
	logic [7:0]  ipart;

	always_comb begin
		p = '0;
		for (int i = 0; i < 27; i++)
			if (x[i])
				p = 5'(i);
		m0 = 31'(x) << (5'd30 - p);
		sq = 62'(m_q) * 62'(m_q);
		t = sq[61:30];
		ipart = 8'(pexp_q) - 8'd16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'd16;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// square the mantissa, a carry past two gives the next fraction bit
	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= m0;
			pexp_q <= p;
			frac_q <= '0;
		end else if (run_q) begin
			m_q <= t[31] ? t[31:1] : t[30:0];
			frac_q <= {frac_q[14:0], t[31]};
		end
	end

	assign val = $signed({ipart, frac_q});
	assign done = done_q;
endmodule

/* hw/rtl/rgtm_exp2.sv */
module rgtm_exp2 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [45:0] mean,
	output logic [23:0]        avg,
	output logic               done
);
	import rgtm_pkg::*;

	logic [31:0]        root_tab [0:15];
	logic [15:0]        f_q;
	logic signed [29:0] n_q;
	logic [30:0]        acc_q;
	logic [3:0]         idx_q;
	logic               run_q;
	logic               fin_q;
	logic               done_q;
	logic [23:0]        avg_q;
	logic [62:0]        prod;
	logic signed [30:0] s;
	logic [30:0]        shifted;
	logic [23:0]        avg_c;

	for (genvar gi = 0; gi < 16; gi++) begin : g_root
		localparam logic [31:0] RV = exp2_root(gi + 1);
		assign root_tab[gi] = RV;
	end

	always_comb begin
		prod = 63'(acc_q) * 63'(root_tab[idx_q]);
		s = $signed(31'd14) - 31'(n_q);
		shifted = acc_q >> s[4:0];
		if (s < 0)
			avg_c = AVG_MAX;
		else if (s > 31'sd30)
			avg_c = '0;
		else if (shifted > 31'(AVG_MAX))
			avg_c = AVG_MAX;
		else
			avg_c = shifted[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				idx_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == 4'd15) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			f_q <= mean[15:0];
			n_q <= mean[45:16];
			acc_q <= 31'd1 << 30;
		end else if (run_q) begin
			if (f_q[15])
				acc_q <= prod[60:30];
			f_q <= {f_q[14:0], 1'b0};
		end
		if (fin_q)
			avg_q <= avg_c;
	end

	assign avg = avg_q;
	assign done = done_q;
endmodule
